// ===== design/assert_macros.svh =====
// Assertion macros used by the register file of the DMA register block RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== design/isadma_pkg.sv =====
// Types and constants of the ISA DMA register block.
package isadma_pkg;

    localparam int CHANNEL_REGS = 8;
    localparam int CH_IDX_W     = $clog2(CHANNEL_REGS);

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] REGION_FIRST  = 2'd0;
    localparam logic [1:0] REGION_SECOND = 2'd1;
    localparam logic [1:0] REGION_PAGE   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNHANDLED = 2'd1;
    localparam logic [1:0] ST_CHANNEL   = 2'd2;
    localparam logic [1:0] ST_SIZE      = 2'd3;

    localparam logic [4:0] REG_CMD          = 5'd8;
    localparam logic [4:0] REG_MASK         = 5'd10;
    localparam logic [4:0] REG_MODE         = 5'd11;
    localparam logic [4:0] REG_FF_CLEAR     = 5'd12;
    localparam logic [4:0] REG_MASTER_CLEAR = 5'd13;

    localparam logic [3:0] MASK_WRITE_VALUE = 4'hF;
    localparam logic [2:0] QUERY_CHANNEL    = 3'd2;
    // channel 2 uses address register 4 and count register 5 of the first controller
    localparam logic [CH_IDX_W-1:0] QUERY_ADDR_REG  = CH_IDX_W'(4);
    localparam logic [CH_IDX_W-1:0] QUERY_COUNT_REG = CH_IDX_W'(5);

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  region;
        logic [4:0]  offset;
        logic [7:0]  write_data;
        logic [2:0]  channel;
        logic [16:0] max_bytes;
    } t_request;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [1:0]  status;
        logic [23:0] dma_address;
        logic [16:0] dma_count;
    } t_result;

endpackage

// ===== design/isadma_regfile.sv =====
// Controller and page register state with single-pass request decode.
`include "assert_macros.svh"

module isadma_regfile #(
    parameter int PAGE_REGS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_exec,
    input  isadma_pkg::t_request  i_req,
    output isadma_pkg::t_result   o_res
);

    localparam int PW = $clog2(PAGE_REGS);
    localparam int CW = isadma_pkg::CH_IDX_W;
    // byte index: controller, register, byte select
    localparam int BW = CW + 2;

    logic [7:0] r_bytes [2**BW];
    logic       r_ff    [2**(CW+1)];
    logic [7:0] r_cmd   [2];
    logic [7:0] r_mode  [2];
    logic [3:0] r_mask  [2];
    logic [7:0] r_page  [PAGE_REGS];

    logic          ctrl;
    logic [4:0]    reg_sel;
    logic [CW:0]   fi;
    logic          ff;
    logic [BW-1:0] bi;
    logic [PW-1:0] pidx;
    logic          is_write;
    logic          chan_acc;
    logic          we_page;
    logic          we_cmd;
    logic          we_mask;
    logic          we_mode;
    logic          ff_clear;
    logic          mclear;
    logic [16:0]   count_p1;
    logic [23:0]   q_addr;

    assign ctrl     = (i_req.region == isadma_pkg::REGION_SECOND);
    assign reg_sel  = ctrl ? {1'b0, i_req.offset[4:1]} : i_req.offset;
    assign fi       = {ctrl, reg_sel[CW-1:0]};
    assign ff       = r_ff[fi];
    assign bi       = {fi, ff};
    assign pidx     = i_req.offset[PW-1:0];
    assign is_write = (i_req.op == isadma_pkg::OP_WRITE);

    assign q_addr   = {r_page[1],
                       r_bytes[{1'b0, isadma_pkg::QUERY_ADDR_REG, 1'b1}],
                       r_bytes[{1'b0, isadma_pkg::QUERY_ADDR_REG, 1'b0}]};
    assign count_p1 = {1'b0, r_bytes[{1'b0, isadma_pkg::QUERY_COUNT_REG, 1'b1}],
                             r_bytes[{1'b0, isadma_pkg::QUERY_COUNT_REG, 1'b0}]} + 17'd1;

    always_comb begin
        o_res    = '0;
        chan_acc = 1'b0;
        we_page  = 1'b0;
        we_cmd   = 1'b0;
        we_mask  = 1'b0;
        we_mode  = 1'b0;
        ff_clear = 1'b0;
        mclear   = 1'b0;
        unique case (i_req.op)
            isadma_pkg::OP_READ, isadma_pkg::OP_WRITE: begin
                if (i_req.region == isadma_pkg::REGION_PAGE) begin
                    if (32'(i_req.offset) < PAGE_REGS) begin
                        we_page = is_write;
                        if (!is_write) begin
                            o_res.read_data = r_page[pidx];
                        end
                    end else begin
                        o_res.status = isadma_pkg::ST_UNHANDLED;
                    end
                end else if (i_req.region == isadma_pkg::REGION_FIRST || ctrl) begin
                    if (32'(reg_sel) < isadma_pkg::CHANNEL_REGS) begin
                        chan_acc = 1'b1;
                        if (!is_write) begin
                            o_res.read_data = r_bytes[bi];
                        end
                    end else if (is_write) begin
                        unique case (reg_sel)
                            isadma_pkg::REG_CMD:          we_cmd   = 1'b1;
                            isadma_pkg::REG_MASK:         we_mask  = 1'b1;
                            isadma_pkg::REG_MODE:         we_mode  = 1'b1;
                            isadma_pkg::REG_FF_CLEAR:     ff_clear = (i_req.write_data != 8'd0);
                            isadma_pkg::REG_MASTER_CLEAR: mclear   = 1'b1;
                            default: o_res.status = isadma_pkg::ST_UNHANDLED;
                        endcase
                    end else begin
                        unique case (reg_sel)
                            isadma_pkg::REG_CMD:  o_res.read_data = r_cmd[ctrl];
                            isadma_pkg::REG_MASK: o_res.read_data = {4'd0, r_mask[ctrl]};
                            isadma_pkg::REG_MODE: o_res.read_data = r_mode[ctrl];
                            default: o_res.status = isadma_pkg::ST_UNHANDLED;
                        endcase
                    end
                end else begin
                    o_res.status = isadma_pkg::ST_UNHANDLED;
                end
            end
            isadma_pkg::OP_QUERY: begin
                if (i_req.channel != isadma_pkg::QUERY_CHANNEL) begin
                    o_res.status = isadma_pkg::ST_CHANNEL;
                end else if (count_p1 > i_req.max_bytes) begin
                    o_res.status = isadma_pkg::ST_SIZE;
                end else begin
                    o_res.dma_address = q_addr;
                    o_res.dma_count   = count_p1;
                end
            end
            default: o_res.status = isadma_pkg::ST_UNHANDLED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2**BW; i++) r_bytes[i] <= '0;
            for (int i = 0; i < 2**(CW+1); i++) r_ff[i] <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_cmd[i]  <= '0;
                r_mode[i] <= '0;
                r_mask[i] <= '0;
            end
            for (int i = 0; i < PAGE_REGS; i++) r_page[i] <= '0;
        end else if (i_exec) begin
            if (we_page) begin
                r_page[pidx] <= i_req.write_data;
            end
            if (chan_acc) begin
                if (is_write) begin
                    r_bytes[bi] <= i_req.write_data;
                end
                r_ff[fi] <= ~ff;
            end
            if (we_cmd)  r_cmd[ctrl]  <= i_req.write_data;
            if (we_mask) r_mask[ctrl] <= isadma_pkg::MASK_WRITE_VALUE;
            if (we_mode) r_mode[ctrl] <= i_req.write_data;
            if (ff_clear || mclear) begin
                for (int i = 0; i < isadma_pkg::CHANNEL_REGS; i++) begin
                    r_ff[{ctrl, CW'(i)}] <= 1'b0;
                end
            end
            if (mclear) begin
                for (int i = 0; i < 2 * isadma_pkg::CHANNEL_REGS; i++) begin
                    r_bytes[{ctrl, (CW+1)'(i)}] <= '0;
                end
                r_cmd[ctrl]  <= '0;
                r_mode[ctrl] <= '0;
                r_mask[ctrl] <= '0;
            end
        end
    end

    `ASSERT_NEVER(a_err_no_data, i_clk, i_rst_n, (o_res.status != isadma_pkg::ST_OK) && ((o_res.read_data != 8'd0) || (o_res.dma_count != 17'd0)), "error result carries data")
    `ASSERT_PROP(a_query_count, i_clk, i_rst_n, (i_req.op == isadma_pkg::OP_QUERY && o_res.status == isadma_pkg::ST_OK) |-> (o_res.dma_count != 17'd0 && o_res.dma_count <= i_req.max_bytes), "query count out of range")
    `ASSERT_PROP(a_ff_toggle, i_clk, i_rst_n, (i_exec && chan_acc) |=> (r_ff[$past(fi)] != $past(ff)), "byte flip-flop did not toggle")
    `ASSERT_PROP(a_mclear_first, i_clk, i_rst_n, (i_exec && mclear && !ctrl) |=> (r_cmd[0] == 8'd0 && r_mode[0] == 8'd0 && r_mask[0] == 4'd0), "master clear left state")

endmodule

// ===== design/isa_dma_register_block.sv =====
// Top level of the ISA DMA register block: request and result registers around the decode.
//
// Requests enter on the in channel (i_in_valid / o_in_stall) carrying op, region,
// offset, write_data, channel and max_bytes. One result leaves per request on the
// out channel (o_out_valid / i_out_stall) with read_data, status, dma_address and
// dma_count. A request is taken when valid is high and stall is low at a clock edge.
// The request register feeds the register file decode, whose outcome is stored in
// the result register. Throughput is one request per cycle while the receiver does
// not stall; the single-pass decode and state update set that figure.
// While the receiver stalls, the result register holds its request outcome and the
// request register holds the next one; only when both are full does o_in_stall rise.
// Register state is updated at the moment a request moves into the result register,
// so a stalled request has no effect yet.
// Synchronous active-low reset empties both pipeline registers and zeroes all
// controller, flip-flop, command, mode, mask and page registers.
module isa_dma_register_block #(
    parameter int PAGE_REGS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [1:0]  i_region,
    input  logic [4:0]  i_offset,
    input  logic [7:0]  i_write_data,
    input  logic [2:0]  i_channel,
    input  logic [16:0] i_max_bytes,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic [1:0]  o_status,
    output logic [23:0] o_dma_address,
    output logic [16:0] o_dma_count
);

    isadma_pkg::t_request r_req;
    isadma_pkg::t_result  r_res;
    isadma_pkg::t_result  res;
    logic                 r_in_valid;
    logic                 r_out_valid;
    logic                 out_adv;
    logic                 in_adv;
    logic                 exec;

    assign out_adv    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !out_adv;
    assign in_adv     = i_in_valid && !o_in_stall;
    assign exec       = r_in_valid && out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= 1'b1;
        end else if (out_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_req <= '{op: i_op, region: i_region, offset: i_offset,
                       write_data: i_write_data, channel: i_channel,
                       max_bytes: i_max_bytes};
        end
    end

    isadma_regfile #(
        .PAGE_REGS (PAGE_REGS)
    ) u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_exec  (exec),
        .i_req   (r_req),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_res <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_res.read_data;
    assign o_status      = r_res.status;
    assign o_dma_address = r_res.dma_address;
    assign o_dma_count   = r_res.dma_count;

endmodule
